@@ rtl/mqd_pkg.sv @@
package mqd_pkg;

  localparam int MAX_LENGTH_BYTES = 4;
  localparam int LEN_W = 28;
  localparam int CNT_W = 3;

  localparam logic [3:0] TYPE_CONNACK = 4'd2;
  localparam logic [3:0] TYPE_PUBLISH = 4'd3;

  typedef enum logic [2:0] {
    EV_HEADER    = 3'd0,
    EV_TOPIC     = 3'd1,
    EV_ID        = 3'd2,
    EV_PAYLOAD   = 3'd3,
    EV_CONNACK   = 3'd4,
    EV_SKIP_END  = 3'd5,
    EV_MALFORMED = 3'd6
  } event_e;

  typedef enum logic [10:0] {
    PH_HEADER    = 11'b000_0000_0001,
    PH_LENGTH    = 11'b000_0000_0010,
    PH_TLEN_HI   = 11'b000_0000_0100,
    PH_TLEN_LO   = 11'b000_0000_1000,
    PH_TOPIC     = 11'b000_0001_0000,
    PH_ID_HI     = 11'b000_0010_0000,
    PH_ID_LO     = 11'b000_0100_0000,
    PH_PAYLOAD   = 11'b000_1000_0000,
    PH_ACK_FLAGS = 11'b001_0000_0000,
    PH_ACK_CODE  = 11'b010_0000_0000,
    PH_SKIP      = 11'b100_0000_0000
  } phase_e;

  // raw event as classified by the parser
  typedef struct packed {
    event_e            kind;
    logic [3:0]        packet_kind;
    logic [3:0]        flags;
    logic [7:0]        data;
    logic [LEN_W-1:0]  blen;
    logic [15:0]       topic_len;
    logic [15:0]       id;
    logic              session;
    logic [7:0]        rc;
    logic              last;
  } event_t;

  // formatted result
  typedef struct packed {
    logic [2:0]        event_kind;
    logic [3:0]        packet_kind;
    logic [7:0]        data_value;
    logic [1:0]        qos_level;
    logic              dup_flag;
    logic              retain_flag;
    logic [LEN_W-1:0]  body_length;
    logic [15:0]       topic_size;
    logic [15:0]       message_id;
    logic              session_flag;
    logic [7:0]        return_code;
    logic              last;
  } result_t;

endpackage

@@ rtl/mqd_if.sv @@
interface mqd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface mqd_ev_if import mqd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [2:0]       event_kind;
  logic [3:0]       packet_kind;
  logic [7:0]       data_value;
  logic [1:0]       qos_level;
  logic             dup_flag;
  logic             retain_flag;
  logic [LEN_W-1:0] body_length;
  logic [15:0]      topic_size;
  logic [15:0]      message_id;
  logic             session_flag;
  logic [7:0]       return_code;
  logic             last;

  modport source (
    output valid, event_kind, packet_kind, data_value, qos_level, dup_flag, retain_flag,
    output body_length, topic_size, message_id, session_flag, return_code, last,
    input ready
  );
  modport sink (
    input valid, event_kind, packet_kind, data_value, qos_level, dup_flag, retain_flag,
    input body_length, topic_size, message_id, session_flag, return_code, last,
    output ready
  );
endinterface

@@ rtl/mqd_front.sv @@
module mqd_front import mqd_pkg::*; #(
  parameter int MaxLengthBytes = MAX_LENGTH_BYTES
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  mqd_rx_if.sink rx_i,
  input  logic   full_i,
  output logic   push_o,
  output event_t ev_o
);

  localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MaxLengthBytes);

  phase_e           phase_q, phase_d;
  logic [3:0]       kind_q, kind_d;
  logic [3:0]       flags_q, flags_d;
  logic [LEN_W-1:0] accum_q, accum_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [LEN_W-1:0] left_q, left_d;
  logic [15:0]      tlen_q, tlen_d;
  logic [15:0]      tleft_q, tleft_d;
  logic [15:0]      id_q, id_d;
  logic             session_q, session_d;

  logic             accept;
  logic             have;
  logic             body;
  logic             pkt_end;
  logic [7:0]       b;
  logic [LEN_W-1:0] grp;
  logic [LEN_W-1:0] blen;
  event_e           kind;
  logic [7:0]       data;
  logic [7:0]       rc;
  logic             last;
  phase_e           after_topic;

  assign rx_i.ready = ~full_i;
  assign accept     = rx_i.valid & ~full_i;
  assign b          = rx_i.rx_byte;
  assign after_topic = (flags_q[2:1] != 2'd0) ? PH_ID_HI : PH_PAYLOAD;

  always_comb begin
    phase_d   = phase_q;
    kind_d    = kind_q;
    flags_d   = flags_q;
    accum_d   = accum_q;
    cnt_d     = cnt_q;
    left_d    = left_q;
    tlen_d    = tlen_q;
    tleft_d   = tleft_q;
    id_d      = id_q;
    session_d = session_q;
    have      = 1'b0;
    body      = 1'b0;
    pkt_end   = 1'b0;
    kind      = EV_HEADER;
    data      = 8'd0;
    rc        = 8'd0;
    last      = 1'b0;
    blen      = accum_q;
    grp       = '0;

    case (phase_q)
      PH_LENGTH: begin
        case (cnt_q[1:0])
          2'd0:    grp = {21'd0, b[6:0]};
          2'd1:    grp = {14'd0, b[6:0], 7'd0};
          2'd2:    grp = {7'd0, b[6:0], 14'd0};
          default: grp = {b[6:0], 21'd0};
        endcase
        accum_d = accum_q | grp;
        cnt_d   = cnt_q + CNT_W'(1);
        blen    = accum_d;
        if (b[7]) begin
          if (cnt_d >= MaxCnt) begin
            have    = 1'b1;
            kind    = EV_MALFORMED;
            last    = 1'b1;
            phase_d = PH_HEADER;
          end
        end else begin
          left_d = accum_d;
          if (kind_q == TYPE_PUBLISH) begin
            have = 1'b1;
            kind = EV_HEADER;
            if (accum_d == '0) begin
              last    = 1'b1;
              phase_d = PH_HEADER;
            end else begin
              phase_d = PH_TLEN_HI;
            end
          end else if (accum_d == '0) begin
            have    = 1'b1;
            kind    = EV_SKIP_END;
            last    = 1'b1;
            phase_d = PH_HEADER;
          end else begin
            phase_d = (kind_q == TYPE_CONNACK) ? PH_ACK_FLAGS : PH_SKIP;
          end
        end
      end
      PH_TLEN_HI, PH_TLEN_LO, PH_TOPIC, PH_ID_HI, PH_ID_LO, PH_PAYLOAD,
      PH_ACK_FLAGS, PH_ACK_CODE, PH_SKIP: begin
        body = 1'b1;
      end
      default: begin
        kind_d    = b[7:4];
        flags_d   = b[3:0];
        accum_d   = '0;
        cnt_d     = '0;
        left_d    = '0;
        tlen_d    = '0;
        tleft_d   = '0;
        id_d      = '0;
        session_d = 1'b0;
        phase_d   = PH_LENGTH;
      end
    endcase

    if (body) begin
      left_d  = (left_q != '0) ? left_q - LEN_W'(1) : left_q;
      pkt_end = (left_d == '0);
      case (phase_q)
        PH_TLEN_HI: begin
          tlen_d  = {b, 8'd0};
          phase_d = PH_TLEN_LO;
        end
        PH_TLEN_LO: begin
          tlen_d  = {tlen_q[15:8], b};
          tleft_d = {tlen_q[15:8], b};
          phase_d = (tleft_d != 16'd0) ? PH_TOPIC : after_topic;
        end
        PH_TOPIC: begin
          have    = 1'b1;
          kind    = EV_TOPIC;
          data    = b;
          tleft_d = (tleft_q != 16'd0) ? tleft_q - 16'd1 : tleft_q;
          if (tleft_d == 16'd0) phase_d = after_topic;
        end
        PH_ID_HI: begin
          id_d    = {b, 8'd0};
          phase_d = PH_ID_LO;
        end
        PH_ID_LO: begin
          id_d    = {id_q[15:8], b};
          have    = 1'b1;
          kind    = EV_ID;
          phase_d = PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          have = 1'b1;
          kind = EV_PAYLOAD;
          data = b;
        end
        PH_ACK_FLAGS: begin
          session_d = b[0];
          phase_d   = PH_ACK_CODE;
        end
        PH_ACK_CODE: begin
          have    = 1'b1;
          kind    = EV_CONNACK;
          rc      = b;
          phase_d = PH_SKIP;
        end
        default: begin
        end
      endcase
      if (pkt_end) begin
        if (!have) begin
          have = 1'b1;
          kind = EV_SKIP_END;
        end
        last    = 1'b1;
        phase_d = PH_HEADER;
      end
    end
  end

  assign push_o = accept & have;

  always_comb begin
    ev_o.kind        = kind;
    ev_o.packet_kind = kind_d;
    ev_o.flags       = flags_d;
    ev_o.data        = data;
    ev_o.blen        = blen;
    ev_o.topic_len   = tlen_d;
    ev_o.id          = id_d;
    ev_o.session     = session_d;
    ev_o.rc          = rc;
    ev_o.last        = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      kind_q    <= '0;
      flags_q   <= '0;
      accum_q   <= '0;
      cnt_q     <= '0;
      left_q    <= '0;
      tlen_q    <= '0;
      tleft_q   <= '0;
      id_q      <= '0;
      session_q <= 1'b0;
    end else if (accept) begin
      phase_q   <= phase_d;
      kind_q    <= kind_d;
      flags_q   <= flags_d;
      accum_q   <= accum_d;
      cnt_q     <= cnt_d;
      left_q    <= left_d;
      tlen_q    <= tlen_d;
      tleft_q   <= tleft_d;
      id_q      <= id_d;
      session_q <= session_d;
    end
  end

endmodule

@@ rtl/mqd_queue.sv @@
module mqd_queue import mqd_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  event_t entry_i,
  output logic   full_o,
  output logic   valid_o,
  output event_t entry_o,
  input  logic   pop_i
);

  event_t     mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= entry_i;
  end

endmodule

@@ rtl/mqd_back.sv @@
module mqd_back import mqd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  input  event_t   entry_i,
  output logic     pop_o,
  mqd_ev_if.source ev_o
);

  logic    valid_q, valid_d;
  result_t res_q, res_d;
  logic    is_pub;
  logic    is_ack;

  assign pop_o  = valid_i & (~valid_q | ev_o.ready);
  assign is_pub = (entry_i.packet_kind == TYPE_PUBLISH);
  assign is_ack = (entry_i.packet_kind == TYPE_CONNACK);

  always_comb begin
    res_d.event_kind   = entry_i.kind;
    res_d.packet_kind  = entry_i.packet_kind;
    res_d.data_value   = entry_i.data;
    res_d.qos_level    = is_pub ? entry_i.flags[2:1] : 2'd0;
    res_d.dup_flag     = is_pub & entry_i.flags[0];
    res_d.retain_flag  = is_pub & entry_i.flags[3];
    res_d.body_length  = (entry_i.kind == EV_MALFORMED) ? '0 : entry_i.blen;
    res_d.topic_size   = is_pub ? entry_i.topic_len : 16'd0;
    res_d.message_id   = is_pub ? entry_i.id : 16'd0;
    res_d.session_flag = is_ack & entry_i.session;
    res_d.return_code  = entry_i.rc;
    res_d.last         = entry_i.last;
    valid_d            = pop_o | (valid_q & ~ev_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) res_q <= res_d;
  end

  assign ev_o.valid        = valid_q;
  assign ev_o.event_kind   = res_q.event_kind;
  assign ev_o.packet_kind  = res_q.packet_kind;
  assign ev_o.data_value   = res_q.data_value;
  assign ev_o.qos_level    = res_q.qos_level;
  assign ev_o.dup_flag     = res_q.dup_flag;
  assign ev_o.retain_flag  = res_q.retain_flag;
  assign ev_o.body_length  = res_q.body_length;
  assign ev_o.topic_size   = res_q.topic_size;
  assign ev_o.message_id   = res_q.message_id;
  assign ev_o.session_flag = res_q.session_flag;
  assign ev_o.return_code  = res_q.return_code;
  assign ev_o.last         = res_q.last;

endmodule

@@ rtl/mqtt_packet_deframer.sv @@
// channel  dir  payload                                   handshake
// rx_i     in   rx_byte                                   valid/ready
// ev_o     out  event_kind .. last (12 fields)            valid/ready
//
// one byte per cycle unless the queue is full; the parser decides its event in that cycle
// an event reaches ev_o through the event queue, then the output register
// rx_i.ready drops only while the two-entry event queue is full
// reset is asynchronous, active low, and leaves the parser waiting for a fixed header
module mqtt_packet_deframer import mqd_pkg::*; #(
  parameter int MaxLengthBytes = MAX_LENGTH_BYTES
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  mqd_rx_if.sink   rx_i,
  mqd_ev_if.source ev_o
);

  logic   push;
  logic   full;
  logic   q_valid;
  logic   pop;
  event_t ev_in;
  event_t ev_out;

  mqd_front #(
    .MaxLengthBytes(MaxLengthBytes)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_i),
    .full_i (full),
    .push_o (push),
    .ev_o   (ev_in)
  );

  mqd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (ev_in),
    .full_o  (full),
    .valid_o (q_valid),
    .entry_o (ev_out),
    .pop_i   (pop)
  );

  mqd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .entry_i (ev_out),
    .pop_o   (pop),
    .ev_o    (ev_o)
  );

endmodule
